### sv/bufut_pkg.sv
`timescale 1ns / 1ps
package bufut_pkg;

	localparam int FIFO_DEPTH_DEF = 64;
	localparam int DATA_BITS      = 8;

	// bit position codes: START_POS = start bit next, 1..8 data bit next
	localparam logic [3:0] START_POS = 4'd0;
	localparam logic [3:0] STOP_POS  = 4'd9;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [DATA_BITS-1:0] data;
	} cmd_t;

	typedef struct packed {
		logic tx_line;
		logic write_accepted;
		logic fifo_full;
		logic fifo_empty;
	} res_t;

endpackage

### sv/bufut_fifo2.sv
`timescale 1ns / 1ps
module bufut_fifo2 #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	logic [W-1:0] slot_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("queue count out of range");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wp_q == rp_q))
		else $error("queue pointers disagree with count");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("queue count did not grow on push");

endmodule

### sv/bufut_front.sv
`timescale 1ns / 1ps
module bufut_front
	import bufut_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 req_type,
	input  logic [DATA_BITS-1:0] data_byte,
	output logic                 full,
	input  logic                 cmd_pop,
	output cmd_t                 cmd,
	output logic                 cmd_empty
);

	cmd_t                      cmd_in;
	logic [$bits(cmd_t)-1:0]   cmd_raw;

	// tick items carry no byte; keep the payload quiet for them
	always_comb begin
		cmd_in.op   = req_type ? OP_TICK : OP_WRITE;
		cmd_in.data = req_type ? '0 : data_byte;
	end

	bufut_fifo2 #(
		.W($bits(cmd_t))
	) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cmd_in),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd_raw),
		.empty (cmd_empty)
	);

	assign cmd = cmd_t'(cmd_raw);

endmodule

### sv/bufut_back.sv
`timescale 1ns / 1ps
module bufut_back
	import bufut_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	input  logic res_full,
	output logic res_push,
	output res_t res
);

	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam logic [AW-1:0] LAST = AW'(FIFO_DEPTH - 1);

	logic [DATA_BITS-1:0] mem_q [FIFO_DEPTH];
	logic [DATA_BITS-1:0] rd_data_q;

	logic [AW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_n, rd_ptr_n;
	logic          full_q, full_n;
	logic [3:0]    bitpos_q, bitpos_n;
	logic          line_q, line_n;
	logic          accepted;
	logic          has_data;
	logic          fire;
	logic          mem_we;
	logic [3:0]    bit_idx;
	logic [AW-1:0] wr_ptr_inc, rd_ptr_inc;

	assign fire     = cmd_valid & ~res_full;
	assign cmd_pop  = fire;
	assign res_push = fire;
	assign has_data = full_q | (wr_ptr_q != rd_ptr_q);
	assign mem_we   = fire & (cmd.op == OP_WRITE) & ~full_q;
	assign bit_idx  = bitpos_q - 4'd1;

	assign wr_ptr_inc = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
	assign rd_ptr_inc = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;

	// store: one write port, registered read of the head entry.
	// The head entry is never rewritten while it is being sent, and a start
	// bit always lies between its write or a pointer move and its data bits.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_ptr_q] <= cmd.data;
		end
		rd_data_q <= mem_q[rd_ptr_q];
	end

	always_comb begin
		wr_ptr_n = wr_ptr_q;
		rd_ptr_n = rd_ptr_q;
		full_n   = full_q;
		bitpos_n = bitpos_q;
		line_n   = line_q;
		accepted = 1'b0;
		unique case (cmd.op)
			OP_WRITE: begin
				if (!full_q) begin
					wr_ptr_n = wr_ptr_inc;
					full_n   = (wr_ptr_inc == rd_ptr_q);
					accepted = 1'b1;
				end
			end
			OP_TICK: begin
				if (has_data) begin
					priority if (bitpos_q == START_POS) begin
						line_n   = 1'b0;
						bitpos_n = 4'd1;
					end else if (bitpos_q < STOP_POS) begin
						line_n   = rd_data_q[bit_idx[2:0]];
						bitpos_n = bitpos_q + 4'd1;
					end else begin
						line_n   = 1'b1;
						rd_ptr_n = rd_ptr_inc;
						bitpos_n = START_POS;
						full_n   = 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res.tx_line        = line_n;
		res.write_accepted = accepted;
		res.fifo_full      = full_n;
		res.fifo_empty     = ~(full_n | (wr_ptr_n != rd_ptr_n));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			full_q   <= 1'b0;
			bitpos_q <= START_POS;
			line_q   <= 1'b1;
		end else if (fire) begin
			wr_ptr_q <= wr_ptr_n;
			rd_ptr_q <= rd_ptr_n;
			full_q   <= full_n;
			bitpos_q <= bitpos_n;
			line_q   <= line_n;
		end
	end

	a_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> (wr_ptr_q == rd_ptr_q))
		else $error("full flag set with pointers apart");

	a_bitpos_range: assert property (@(posedge clk) disable iff (!arst_n)
		bitpos_q <= STOP_POS)
		else $error("bit position out of range");

	a_idle_high: assert property (@(posedge clk) disable iff (!arst_n)
		(bitpos_q == START_POS) |-> line_q)
		else $error("line low between frames");

	a_drop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && cmd.op == OP_WRITE && full_q) |=> $stable(wr_ptr_q))
		else $error("write pointer moved on dropped item");

endmodule

### sv/buffered_uart_transmitter.sv
`timescale 1ns / 1ps
// Buffered 8N1 serial transmitter. Each item is a byte write (req_type 0) or
// one bit-period tick (req_type 1); each item gives one result with the line
// level after it, whether the byte was stored, and the byte store's full and
// empty flags. A write into a full store is dropped. Ticks send start bit,
// eight data bits LSB first and stop bit, then release the entry. One item
// is accepted every clock cycle while the input queue holds an item and
// the result queue has room: the transmit engine updates its state once
// per accepted item and the byte store has one write port and one
// registered read of the head entry. A result is queued as its item leaves
// the input queue; two-entry queues on both sides absorb short stalls.
module buffered_uart_transmitter
	import bufut_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 req_type,
	input  logic [DATA_BITS-1:0] data_byte,
	output logic                 empty,
	input  logic                 pop,
	output logic                 tx_line,
	output logic                 write_accepted,
	output logic                 fifo_full,
	output logic                 fifo_empty
);

	cmd_t                    cmd;
	logic                    cmd_empty;
	logic                    cmd_pop;
	logic                    res_full;
	logic                    res_push;
	res_t                    res_in;
	logic [$bits(res_t)-1:0] res_raw;
	res_t                    res_out;

	bufut_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.req_type (req_type),
		.data_byte(data_byte),
		.full     (full),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.cmd_empty(cmd_empty)
	);

	bufut_back #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(~cmd_empty),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	bufut_fifo2 #(
		.W($bits(res_t))
	) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_raw),
		.empty (empty)
	);

	assign res_out        = res_t'(res_raw);
	assign tx_line        = res_out.tx_line;
	assign write_accepted = res_out.write_accepted;
	assign fifo_full      = res_out.fifo_full;
	assign fifo_empty     = res_out.fifo_empty;

endmodule
